@@ rtl/core/sssg_pkg.sv @@
// Shared types, constants and helpers for the spiral scan step generator.
// Used by sssg_div, sssg_cordic and spiral_scan_step_generator_top.
package sssg_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_TURN_COUNT = 3'd0;
  localparam logic [2:0] REG_SPACING    = 3'd1;
  localparam logic [2:0] REG_STEP_TOTAL = 3'd2;
  localparam logic [2:0] REG_AUTO_MODE  = 3'd3;
  localparam logic [2:0] REG_POWER_THR  = 3'd4;

  // Reset values of the configuration registers
  localparam logic [6:0]  TURN_COUNT_RST = 7'd5;
  localparam logic [11:0] SPACING_RST    = 12'd100;
  localparam logic [15:0] STEP_TOTAL_RST = 16'd1000;
  localparam logic [15:0] POWER_THR_RST  = 16'd32768;

  // Divider: 17 quotient bits, t is unsigned 1.16
  localparam int unsigned DIV_STEPS = 17;

  // CORDIC constants (Q30)
  localparam int unsigned XY_W = 33;
  localparam logic [29:0] QUARTER_PI_Q30 = 30'd843314856;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam int unsigned ATAN_DEPTH = 24;

  localparam logic [31:0] ATAN_Q30 [ATAN_DEPTH] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  localparam logic signed [17:0] TRIG_MAX = 18'sd32767;
  localparam logic [12:0]        STEP_MAX = 13'd8191;

  typedef logic signed [15:0] trig_t;   // Q1.15
  typedef logic signed [13:0] pos_t;    // motor position, steps

  // Clamp an 18-bit value to +/-32767
  function automatic trig_t sat_trig(input logic signed [17:0] v);
    trig_t r;
    if (v > TRIG_MAX) begin
      r = 16'sd32767;
    end else if (v < -TRIG_MAX) begin
      r = -16'sd32767;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/sssg_div.sv @@
// Restoring divider for t = (idx << 16) / last, one quotient bit per clock.
// Depends on sssg_pkg; requires idx <= last and last >= 1.
module sssg_div import sssg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [16:0] quot_o
);

  logic        busy_q, first_q, done_q;
  logic [4:0]  cnt_q;
  logic [15:0] div_q;
  logic [16:0] rem_q, quot_q;
  logic [16:0] rem_cur, rem_sub;
  logic        ge;

  // First step compares idx itself (quotient bit 16), later steps shift in a zero
  assign rem_cur = first_q ? rem_q : {rem_q[15:0], 1'b0};
  assign ge      = rem_cur >= {1'b0, div_q};
  assign rem_sub = rem_cur - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        cnt_q   <= 5'(DIV_STEPS - 1);
      end else if (busy_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, dividend_i};
      div_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? rem_sub : rem_cur;
      quot_q <= {quot_q[15:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ rtl/core/sssg_cordic.sv @@
// Iterative rotation-mode CORDIC: Q0.16 turns in, Q1.15 sine and cosine out.
// One micro-rotation per clock over a shared add/shift datapath; uses sssg_pkg.
module sssg_cordic import sssg_pkg::*; #(
  parameter int unsigned Stages = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] phase_i,
  output logic        done_o,
  output trig_t       sin_o,
  output trig_t       cos_o
);

  localparam int unsigned CntW = $clog2(Stages);

  logic                   run_q, fin_q, done_q;
  logic [CntW-1:0]        k_q;
  logic [1:0]             quad_q;
  logic signed [XY_W-1:0] x_q, y_q, xs, ys, xr, yr;
  logic signed [31:0]     z_q, atan_k;
  logic [43:0]            z_prod;
  logic signed [17:0]     c_r, s_r, s_sel, c_sel;
  trig_t                  sin_q, cos_q;

  assign z_prod = 44'(phase_i[13:0]) * 44'(QUARTER_PI_Q30);
  assign atan_k = $signed(ATAN_Q30[5'(k_q)]);
  assign xs     = x_q >>> k_q;
  assign ys     = y_q >>> k_q;

  // Round to Q1.15, then fold in the quadrant
  assign xr  = x_q + XY_W'(1 << 14);
  assign yr  = y_q + XY_W'(1 << 14);
  assign c_r = xr[32:15];
  assign s_r = yr[32:15];

  always_comb begin
    unique case (quad_q)
      2'd0: begin s_sel = s_r;  c_sel = c_r;  end
      2'd1: begin s_sel = c_r;  c_sel = -s_r; end
      2'd2: begin s_sel = -s_r; c_sel = -c_r; end
      default: begin s_sel = -c_r; c_sel = s_r; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        k_q   <= '0;
      end else if (run_q) begin
        k_q <= k_q + CntW'(1);
        if (k_q == CntW'(Stages - 1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end else if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CORDIC_GAIN_Q30;
      y_q    <= '0;
      z_q    <= $signed(32'(z_prod >> 13));
      quad_q <= phase_i[15:14];
    end else if (run_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_k;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_k;
      end
    end
    if (fin_q) begin
      sin_q <= sat_trig(s_sel);
      cos_q <= sat_trig(c_sel);
    end
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

@@ rtl/core/spiral_scan_step_generator_top.sv @@
// Spiral scan step generator: top level, sequencer, position store, output stage.
// Depends on sssg_pkg, sssg_div and sssg_cordic.
//
//  channel  direction  handshake                     payload
//  s_axis   in         s_axis_tvalid_i/tready_o      tuser: optic_sel; tdata: index, hold, power
//  m_axis   out        m_axis_tvalid_o/tready_i      tuser: optic_out; tdata: moved, dirs, counts
//  cfg      in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i (always ready)
//
// An active item passes through the serial divider (bypassed when step_total is
// 1 or less), the phase multiply, the CORDIC, and two passes (X then Y) through
// the shared multiply / difference / round / clamp steps. A skipped item goes
// straight to the final state. One item is in flight at a time; s_axis_tready_o
// is high only when the sequencer is idle. A finished result sits in the output
// register; a stalled m_axis holds the sequencer in its final state.
// rst_ni clears config to defaults, all optic positions to zero, and the sequencer.
module spiral_scan_step_generator_top import sssg_pkg::*; #(
  parameter int unsigned NUM_OPTICS    = 4,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [15:0] step_index, [16] hold_flag,
                                        // [32:17] power_level, [39:33] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] optic_sel
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [0] moved, [1] dir_x, [2] dir_y,
                                        // [15:3] count_x, [28:16] count_y, [31:29] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] optic_out
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IdxW = (NUM_OPTICS > 1) ? $clog2(NUM_OPTICS) : 1;

  // Sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DIV    = 4'd1;
  localparam logic [3:0] ST_PHASE  = 4'd2;
  localparam logic [3:0] ST_CSTART = 4'd3;
  localparam logic [3:0] ST_TRIG   = 4'd4;
  localparam logic [3:0] ST_MUL    = 4'd5;
  localparam logic [3:0] ST_DIFF   = 4'd6;
  localparam logic [3:0] ST_ROUND  = 4'd7;
  localparam logic [3:0] ST_POS    = 4'd8;
  localparam logic [3:0] ST_FIN    = 4'd9;

  // ---------------- configuration ----------------
  logic [6:0]  turn_count_q;
  logic [11:0] spacing_q;
  logic [15:0] step_total_q;
  logic        auto_mode_q;
  logic [15:0] power_thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_count_q <= TURN_COUNT_RST;
      spacing_q    <= SPACING_RST;
      step_total_q <= STEP_TOTAL_RST;
      auto_mode_q  <= 1'b0;
      power_thr_q  <= POWER_THR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TURN_COUNT: turn_count_q <= cfg_data_i[6:0];
        REG_SPACING:    spacing_q    <= cfg_data_i[11:0];
        REG_STEP_TOTAL: step_total_q <= cfg_data_i;
        REG_AUTO_MODE:  auto_mode_q  <= cfg_data_i[0];
        REG_POWER_THR:  power_thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- input decode ----------------
  logic        in_xfer;
  logic [1:0]  in_sel;
  logic [15:0] in_idx, in_power, last, idx_cl;
  logic        in_hold, in_skip, single;

  assign in_sel   = s_axis_tuser_i;
  assign in_idx   = s_axis_tdata_i[15:0];
  assign in_hold  = s_axis_tdata_i[16];
  assign in_power = s_axis_tdata_i[32:17];
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;

  assign in_skip = (32'(in_sel) >= NUM_OPTICS) ||
                   (auto_mode_q && (in_hold || (in_power >= power_thr_q)));
  assign single  = step_total_q <= 16'd1;
  assign last    = step_total_q - 16'd1;
  assign idx_cl  = (in_idx > last) ? last : in_idx;   // index past the end -> t = 1

  // ---------------- shared units ----------------
  logic [3:0]  state_q;
  logic        div_start, div_done, cord_start, cord_done;
  logic [16:0] div_quot;
  trig_t       cord_sin, cord_cos;

  assign div_start  = in_xfer && !in_skip && !single;
  assign cord_start = state_q == ST_CSTART;

  sssg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (idx_cl),
    .divisor_i  (last),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  logic [47:0] prod_q;

  sssg_cordic #(
    .Stages (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .phase_i (prod_q[15:0]),
    .done_o  (cord_done),
    .sin_o   (cord_sin),
    .cos_o   (cord_cos)
  );

  // ---------------- datapath ----------------
  logic [1:0]         opt_q;
  logic [16:0]        t_q;
  logic [28:0]        st_q;      // spacing * t
  trig_t              sin_q, cos_q;
  logic               axis_q;    // 0: X, 1: Y
  logic signed [47:0] d_q;
  pos_t               step_q, taken_x_q, taken_y_q;
  logic               moved_q;
  pos_t               pos_x_q [NUM_OPTICS];
  pos_t               pos_y_q [NUM_OPTICS];

  logic [IdxW-1:0]    opt_idx;
  pos_t               pos_cur;
  logic [29:0]        mul_a;
  logic signed [16:0] mul_b;
  logic signed [47:0] mul_p, pos_sh, abs_d, rnd;
  logic [16:0]        mag_full;
  logic [12:0]        mag;
  logic signed [14:0] np_w;
  pos_t               np, taken;

  assign opt_idx = IdxW'(opt_q);
  assign pos_cur = axis_q ? pos_y_q[opt_idx] : pos_x_q[opt_idx];

  // One multiplier serves phase, spacing*t and both target products
  always_comb begin
    unique case (state_q)
      ST_PHASE: begin
        mul_a = 30'(t_q);
        mul_b = $signed({10'd0, turn_count_q});
      end
      ST_CSTART: begin
        mul_a = 30'(t_q);
        mul_b = $signed({5'd0, spacing_q});
      end
      default: begin
        mul_a = {1'b0, st_q};
        mul_b = axis_q ? {cos_q[15], cos_q} : {sin_q[15], sin_q};
      end
    endcase
  end
  assign mul_p = 48'($signed({1'b0, mul_a}) * mul_b);

  // target*2^31 - pos*2^31
  assign pos_sh = {{3{pos_cur[13]}}, pos_cur, 31'd0};

  // round half away from zero, saturate magnitude
  assign abs_d    = d_q[47] ? -d_q : d_q;
  assign rnd      = abs_d + 48'(1 << 30);
  assign mag_full = rnd[47:31];
  assign mag      = (mag_full > 17'(STEP_MAX)) ? STEP_MAX : mag_full[12:0];

  // new position clamped to the 14-bit range; report the step really taken
  assign np_w  = {pos_cur[13], pos_cur} + {step_q[13], step_q};
  assign np    = (np_w > 15'sd8191) ? 14'sd8191 :
                 (np_w < -15'sd8192) ? -14'sd8192 : np_w[13:0];
  assign taken = np - pos_cur;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      opt_q <= in_sel;
      t_q   <= '0;
    end
    if (div_done) begin
      t_q <= div_quot;
    end
    if (state_q == ST_PHASE || state_q == ST_CSTART || state_q == ST_MUL) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_TRIG) begin
      st_q <= prod_q[28:0];
    end
    if (cord_done) begin
      sin_q <= cord_sin;
      cos_q <= cord_cos;
    end
    if (state_q == ST_DIFF) begin
      d_q <= $signed(prod_q) - pos_sh;
    end
    if (state_q == ST_ROUND) begin
      step_q <= d_q[47] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  // ---------------- sequencer, positions, output stage ----------------
  logic [3:0] state_d;
  logic       out_load;

  assign out_load = (state_q == ST_FIN) && (!m_axis_tvalid_o || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = in_skip ? ST_FIN : (single ? ST_PHASE : ST_DIV);
        end
      end
      ST_DIV:    if (div_done) state_d = ST_PHASE;
      ST_PHASE:  state_d = ST_CSTART;
      ST_CSTART: state_d = ST_TRIG;
      ST_TRIG:   if (cord_done) state_d = ST_MUL;
      ST_MUL:    state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_ROUND;
      ST_ROUND:  state_d = ST_POS;
      ST_POS:    state_d = axis_q ? ST_FIN : ST_MUL;
      ST_FIN:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  logic        m_valid_q;
  logic [31:0] m_data_q;
  logic [1:0]  m_user_q;
  logic [12:0] cnt_x, cnt_y;

  assign cnt_x = taken_x_q[13] ? 13'(-taken_x_q) : taken_x_q[12:0];
  assign cnt_y = taken_y_q[13] ? 13'(-taken_y_q) : taken_y_q[12:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      axis_q    <= 1'b0;
      moved_q   <= 1'b0;
      taken_x_q <= '0;
      taken_y_q <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < NUM_OPTICS; i++) begin
        pos_x_q[i] <= '0;
        pos_y_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        moved_q   <= !in_skip;
        taken_x_q <= '0;
        taken_y_q <= '0;
      end
      if (cord_done) begin
        axis_q <= 1'b0;
      end
      if (state_q == ST_POS) begin
        axis_q <= 1'b1;
        if (axis_q) begin
          pos_y_q[opt_idx] <= np;
          taken_y_q        <= taken;
        end else begin
          pos_x_q[opt_idx] <= np;
          taken_x_q        <= taken;
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_user_q <= opt_q;
      m_data_q <= {3'd0, cnt_y, cnt_x, !taken_y_q[13], !taken_x_q[13], moved_q};
    end
  end

  assign s_axis_tready_o = state_q == ST_IDLE;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

`ifndef NO_ASSERTIONS
  // one item in flight: an accepted transaction closes the input side
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready_o)
    else $error("input accepted while an item is in flight");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside its wait state");

  a_cord_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> state_q == ST_TRIG)
    else $error("CORDIC finished outside its wait state");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_FIN))
    else $error("result presented without finishing an item");

  a_skip_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[0]) |->
      (m_axis_tdata_o[28:3] == '0 && m_axis_tdata_o[2:1] == 2'b11))
    else $error("skipped item reports a step");
`endif

endmodule

@@ tb/sv/tb_spiral_scan_step_generator_top.sv @@
// Testbench for spiral_scan_step_generator_top: directed table, then randomized scan phases,
// results scored against a bit-accurate spiral/CORDIC step predictor or a fixed home/skip result.
// Depends on sssg_pkg and the spiral_scan_step_generator_top RTL.
`timescale 1ns / 1ps

module tb_spiral_scan_step_generator_top;
  import sssg_pkg::*;

  localparam int OPTICS       = 4;
  localparam int TRIG_STAGES  = 16;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS  = 75;

  // Expected / observed result, same order as the m_axis fields
  typedef struct packed {
    logic [1:0]  optic;
    logic        moved;
    logic        dir_x;
    logic        dir_y;
    logic [12:0] count_x;
    logic [12:0] count_y;
  } step_result_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;
  // CHK_MODEL: scored by the predictor; CHK_HOME: step of zero; CHK_SKIP: skipped step
  typedef enum logic [1:0] {CHK_MODEL, CHK_HOME, CHK_SKIP} check_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    logic [1:0]  optic;
    logic [15:0] idx;
    logic        hold;
    logic [15:0] power;
    check_e      chk;
  } plan_row_t;

  localparam int PLAN_LEN = 36;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // reset config: index 0 sits at the spiral center
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd0, 16'd0,     1'b0, 16'd0,     CHK_HOME},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd3, 16'd0,     1'b0, 16'd0,     CHK_HOME},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd1, 16'd999,   1'b0, 16'd0,     CHK_MODEL},
    // index past the end, hold/power ignored outside auto mode
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd2, 16'd65535, 1'b1, 16'd65535, CHK_MODEL},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd3, 16'd500,   1'b0, 16'd65535, CHK_MODEL},
    // largest radius, 64 turns, longest scan
    '{ROW_CFG,  REG_SPACING,    16'd4095,  2'd0, 16'd0,     1'b0, 16'd0,     CHK_MODEL},
    '{ROW_CFG,  REG_TURN_COUNT, 16'd64,    2'd0, 16'd0,     1'b0, 16'd0,     CHK_MODEL},
    '{ROW_CFG,  REG_STEP_TOTAL, 16'd65535, 2'd0, 16'd0,     1'b0, 16'd0,     CHK_MODEL},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd0, 16'd65534, 1'b0, 16'd0,     CHK_MODEL},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd0, 16'd65535, 1'b0, 16'd0,     CHK_MODEL},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd1, 16'd32767, 1'b1, 16'd65535, CHK_MODEL},
    // zero turns: phase stuck at 0
    '{ROW_CFG,  REG_TURN_COUNT, 16'd0,     2'd0, 16'd0,     1'b0, 16'd0,     CHK_MODEL},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd2, 16'd40000, 1'b0, 16'd0,     CHK_MODEL},
    '{ROW_CFG,  REG_TURN_COUNT, 16'd1,     2'd0, 16'd0,     1'b0, 16'd0,     CHK_MODEL},
    // single iteration (1 and 0): t = 0, optic walks home, then stays
    '{ROW_CFG,  REG_STEP_TOTAL, 16'd1,     2'd0, 16'd0,     1'b0, 16'd0,     CHK_MODEL},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd0, 16'd1234,  1'b0, 16'd0,     CHK_MODEL},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd0, 16'd65535, 1'b0, 16'd0,     CHK_HOME},
    '{ROW_CFG,  REG_STEP_TOTAL, 16'd0,     2'd0, 16'd0,     1'b0, 16'd0,     CHK_MODEL},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd1, 16'd0,     1'b0, 16'd0,     CHK_MODEL},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd1, 16'd65535, 1'b0, 16'd0,     CHK_HOME},
    '{ROW_CFG,  REG_STEP_TOTAL, 16'd2,     2'd0, 16'd0,     1'b0, 16'd0,     CHK_MODEL},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd3, 16'd1,     1'b0, 16'd0,     CHK_MODEL},
    // auto mode: hold flag and power at/above threshold skip
    '{ROW_CFG,  REG_AUTO_MODE,  16'd1,     2'd0, 16'd0,     1'b0, 16'd0,     CHK_MODEL},
    '{ROW_CFG,  REG_POWER_THR,  16'd100,   2'd0, 16'd0,     1'b0, 16'd0,     CHK_MODEL},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd0, 16'd0,     1'b1, 16'd0,     CHK_SKIP},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd1, 16'd0,     1'b0, 16'd100,   CHK_SKIP},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd2, 16'd1,     1'b0, 16'd99,    CHK_MODEL},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd3, 16'd1,     1'b0, 16'd65535, CHK_SKIP},
    '{ROW_CFG,  REG_POWER_THR,  16'd0,     2'd0, 16'd0,     1'b0, 16'd0,     CHK_MODEL},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd0, 16'd1,     1'b0, 16'd0,     CHK_SKIP},
    '{ROW_CFG,  REG_POWER_THR,  16'd65535, 2'd0, 16'd0,     1'b0, 16'd0,     CHK_MODEL},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd1, 16'd1,     1'b0, 16'd65535, CHK_SKIP},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd2, 16'd0,     1'b0, 16'd65534, CHK_MODEL},
    // zero radius pulls the optic back to center
    '{ROW_CFG,  REG_SPACING,    16'd0,     2'd0, 16'd0,     1'b0, 16'd0,     CHK_MODEL},
    '{ROW_ITEM, REG_TURN_COUNT, 16'd0,     2'd2, 16'd1,     1'b0, 16'd0,     CHK_MODEL},
    '{ROW_CFG,  REG_AUTO_MODE,  16'd0,     2'd0, 16'd0,     1'b0, 16'd0,     CHK_MODEL}
  };

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i  = '0;  // [15:0] step_index, [16] hold_flag, [32:17] power_level
  logic [1:0]  s_axis_tuser_i  = '0;  // [1:0] optic_sel
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;        // [0] moved, [1] dir_x, [2] dir_y, [15:3] count_x,
                                      // [28:16] count_y
  logic [1:0]  m_axis_tuser_o;        // [1:0] optic_out
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i     = '0;
  logic [15:0] cfg_data_i      = '0;

  spiral_scan_step_generator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Predictor copy of the configuration and the per-optic positions
  logic [6:0]  cfg_turns;
  logic [11:0] cfg_spacing;
  logic [15:0] cfg_total;
  logic        cfg_auto;
  logic [15:0] cfg_thresh;
  pos_t        track_x [OPTICS];
  pos_t        track_y [OPTICS];

  step_result_t pending_steps [$];
  int  fail_count    = 0;
  int  results_seen  = 0;
  bit  steady_flow   = 1'b0;  // both sides run without gaps
  bit  long_hold_done = 1'b0;

  // Sine/cosine (Q1.15) of a phase given in Q0.16 turns
  function automatic void spiral_trig(input logic [15:0] phase, output trig_t sin_v,
                                      output trig_t cos_v);
    longint x, y, z, xs, ys, s, c, ts, tc;
    x = longint'(CORDIC_GAIN_Q30);
    y = 0;
    z = (longint'(phase[13:0]) * longint'(QUARTER_PI_Q30)) >>> 13;
    for (int k = 0; k < TRIG_STAGES; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_Q30[k]);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_Q30[k]);
      end
    end
    c = (x + 64'sd16384) >>> 15;
    s = (y + 64'sd16384) >>> 15;
    case (phase[15:14])
      2'd0: begin ts = s;  tc = c;  end
      2'd1: begin ts = c;  tc = -s; end
      2'd2: begin ts = -s; tc = -c; end
      default: begin ts = -c; tc = s; end
    endcase
    if (ts > 32767) ts = 32767;
    if (ts < -32767) ts = -32767;
    if (tc > 32767) tc = 32767;
    if (tc < -32767) tc = -32767;
    sin_v = trig_t'(ts);
    cos_v = trig_t'(tc);
  endfunction

  // Moves one axis toward a target scaled by 2^31; returns the signed step taken
  function automatic int axis_move(inout pos_t p, input longint target);
    longint d, mag, steps, np;
    d = target - longint'(p) * (longint'(1) << 31);
    mag = (d < 0) ? -d : d;
    mag = (mag + (longint'(1) << 30)) >> 31;
    if (mag > 8191) mag = 8191;
    steps = (d < 0) ? -mag : mag;
    np = longint'(p) + steps;
    if (np > 8191) np = 8191;
    if (np < -8192) np = -8192;
    steps = np - longint'(p);
    p = pos_t'(np);
    return int'(steps);
  endfunction

  function automatic step_result_t spiral_step(input logic [1:0] optic, input logic [15:0] idx,
                                               input logic hold, input logic [15:0] power);
    step_result_t r;
    longint t, last, prod;
    trig_t sin_v, cos_v;
    pos_t px, py;
    int sx, sy;
    r = '{optic, 1'b0, 1'b1, 1'b1, 13'd0, 13'd0};
    if (int'(optic) >= OPTICS || (cfg_auto && (hold || power >= cfg_thresh))) return r;
    t = 0;
    if (cfg_total > 16'd1) begin
      last = longint'(cfg_total) - 1;
      if (longint'(idx) > last) t = 65536;
      else t = (longint'(idx) << 16) / last;
    end
    prod = t * longint'(cfg_turns);
    spiral_trig(prod[15:0], sin_v, cos_v);
    px = track_x[optic];
    py = track_y[optic];
    sx = axis_move(px, longint'(cfg_spacing) * t * longint'(sin_v));
    sy = axis_move(py, longint'(cfg_spacing) * t * longint'(cos_v));
    track_x[optic] = px;
    track_y[optic] = py;
    r.moved   = 1'b1;
    r.dir_x   = (sx >= 0);
    r.dir_y   = (sy >= 0);
    r.count_x = 13'((sx < 0) ? -sx : sx);
    r.count_y = 13'((sy < 0) ? -sy : sy);
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    if (fail_count < 10) $display("%t: %s", $realtime, msg);
    fail_count++;
  endfunction

  // Sender side: all tasks enter and leave at a falling edge
  task automatic quiesce();
    s_axis_tvalid_i <= 1'b0;
    while (pending_steps.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    quiesce();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_TURN_COUNT: cfg_turns   = val[6:0];
      REG_SPACING:    cfg_spacing = val[11:0];
      REG_STEP_TOTAL: cfg_total   = val;
      REG_AUTO_MODE:  cfg_auto    = val[0];
      REG_POWER_THR:  cfg_thresh  = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic send_item(input logic [1:0] optic, input logic [15:0] idx, input logic hold,
                           input logic [15:0] power, input check_e chk);
    step_result_t model, want;
    int gap;
    model = spiral_step(optic, idx, hold, power);
    case (chk)
      CHK_HOME: want = '{optic, 1'b1, 1'b1, 1'b1, 13'd0, 13'd0};
      CHK_SKIP: want = '{optic, 1'b0, 1'b1, 1'b1, 13'd0, 13'd0};
      default:  want = model;
    endcase
    pending_steps.push_back(want);
    cfg_valid_i <= 1'b0;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= optic;
    s_axis_tdata_i  <= {7'd0, power, hold, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Result side: random stall per transaction, one long hold-off to back up the input
  initial begin
    int stall;
    step_result_t got, want;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 9);
      if (!long_hold_done && results_seen == 120) begin
        stall = 400;
        long_hold_done = 1'b1;
      end
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got = '{m_axis_tuser_o, m_axis_tdata_o[0], m_axis_tdata_o[1], m_axis_tdata_o[2],
              m_axis_tdata_o[15:3], m_axis_tdata_o[28:16]};
      if (pending_steps.size() == 0) begin
        note_failure($sformatf("unexpected result optic=%0d moved=%0b", got.optic, got.moved));
      end else begin
        want = pending_steps.pop_front();
        if (got !== want)
          note_failure($sformatf({"mismatch: exp optic=%0d moved=%0b dir=%0b%0b cnt=%0d/%0d,",
                                  " got optic=%0d moved=%0b dir=%0b%0b cnt=%0d/%0d"},
                                 want.optic, want.moved, want.dir_x, want.dir_y, want.count_x,
                                 want.count_y, got.optic, got.moved, got.dir_x, got.dir_y,
                                 got.count_x, got.count_y));
      end
      results_seen++;
      @(negedge clk_i);
    end
  end

  initial begin
    int unsigned seq_next [OPTICS];
    logic [1:0]  optic;
    logic [15:0] idx;
    cfg_turns   = TURN_COUNT_RST;
    cfg_spacing = SPACING_RST;
    cfg_total   = STEP_TOTAL_RST;
    cfg_auto    = 1'b0;
    cfg_thresh  = POWER_THR_RST;
    for (int k = 0; k < OPTICS; k++) begin
      track_x[k] = '0;
      track_y[k] = '0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (PLAN[r]) begin
      if (PLAN[r].kind == ROW_CFG) write_reg(PLAN[r].reg_idx, PLAN[r].reg_val);
      else send_item(PLAN[r].optic, PLAN[r].idx, PLAN[r].hold, PLAN[r].power, PLAN[r].chk);
    end

    // Random scan phases: mostly in-order spiral walks per optic, some stray indexes
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      steady_flow = (ph == 2);
      write_reg(REG_TURN_COUNT, 16'($urandom_range(1, 64)));
      write_reg(REG_SPACING, 16'($urandom_range(0, 4095)));
      write_reg(REG_STEP_TOTAL, ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                16'($urandom_range(2, 40)));
      write_reg(REG_AUTO_MODE, 16'($urandom_range(0, 1)));
      write_reg(REG_POWER_THR, 16'($urandom));
      for (int k = 0; k < OPTICS; k++) seq_next[k] = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == 40) quiesce();  // let the pipe run dry mid-phase
        optic = 2'($urandom_range(0, OPTICS - 1));
        if ($urandom_range(0, 9) < 7) begin
          idx = 16'(seq_next[optic]);
          seq_next[optic] = (seq_next[optic] >= cfg_total) ? 0 : seq_next[optic] + 1;
        end else begin
          idx = 16'($urandom);
        end
        send_item(optic, idx, ($urandom_range(0, 5) == 0), 16'($urandom), CHK_MODEL);
      end
    end

    quiesce();
    repeat (60) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb_spiral_scan_step_generator_top passed");
    end else begin
      $display("tb_spiral_scan_step_generator_top failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("tb_spiral_scan_step_generator_top failed");
    $finish;
  end

endmodule
